FILE: src/json_comment_stripper_unit_macros.svh
// ----------------------------------------------------------------------------
// json_comment_stripper_unit_macros
// assertion macros shared by the checker of the comment stripper
// ----------------------------------------------------------------------------
`ifndef JSON_COMMENT_STRIPPER_UNIT_MACROS_SVH
`define JSON_COMMENT_STRIPPER_UNIT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define JCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a stalled signal keeps its value into the next cycle
`define JCS_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
  `JCS_ASSERT(label, clk, rst_n, (vld && !rdy) |=> $stable(sig), msg)

`endif

FILE: src/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// characters, scan modes and result types of the comment stripper
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef enum logic [6:0] {
    MODE_NORMAL = 7'b0000001,
    MODE_SLASH  = 7'b0000010,
    MODE_LINE   = 7'b0000100,
    MODE_BLOCK  = 7'b0001000,
    MODE_BSTAR  = 7'b0010000,
    MODE_STR    = 7'b0100000,
    MODE_ESC    = 7'b1000000
  } jcs_mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } jcs_res_t;

  typedef struct packed {
    logic [1:0] num;
    jcs_res_t   res0;
    jcs_res_t   res1;
    jcs_mode_e  next_mode;
  } jcs_dec_t;

endpackage

FILE: src/jcs_in_if.sv
// ----------------------------------------------------------------------------
// jcs_in_if
// input channel: one raw text byte per item
// ----------------------------------------------------------------------------
interface jcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

FILE: src/jcs_out_if.sv
// ----------------------------------------------------------------------------
// jcs_out_if
// output channel: one kept text byte per item
// ----------------------------------------------------------------------------
interface jcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: src/jcs_decode.sv
// ----------------------------------------------------------------------------
// jcs_decode
// scan mode transition and kept bytes for one input byte
// ----------------------------------------------------------------------------
module jcs_decode (
  input  jcs_pkg::jcs_mode_e mode_i,
  input  logic [7:0]         in_byte_i,
  input  logic               eos_i,
  output jcs_pkg::jcs_dec_t  dec_o
);
  import jcs_pkg::*;

  jcs_dec_t dec;

  always_comb begin
    dec               = '0;
    dec.res0.out_byte = in_byte_i;
    dec.res0.run_last = 1'b1;
    dec.res1.out_byte = in_byte_i;
    dec.res1.run_last = 1'b1;
    dec.next_mode     = mode_i;
    case (mode_i)
      MODE_SLASH: begin
        if (in_byte_i == CH_SLASH) begin
          dec.next_mode = MODE_LINE;
        end else if (in_byte_i == CH_STAR) begin
          dec.next_mode = MODE_BLOCK;
        end else begin
          // held slash goes out ahead of this byte
          dec.num           = 2'd2;
          dec.res0.out_byte = CH_SLASH;
          dec.res0.run_last = 1'b0;
          dec.next_mode     = (in_byte_i == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (in_byte_i == CH_NL) begin
          dec.num       = 2'd1;
          dec.next_mode = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_byte_i == CH_STAR) begin
          dec.next_mode = MODE_BSTAR;
        end
      end
      MODE_BSTAR: begin
        if (in_byte_i == CH_SLASH) begin
          dec.next_mode = MODE_NORMAL;
        end else if (in_byte_i != CH_STAR) begin
          dec.next_mode = MODE_BLOCK;
        end
      end
      MODE_STR: begin
        dec.num = 2'd1;
        if (in_byte_i == CH_BSLASH) begin
          dec.next_mode = MODE_ESC;
        end else if (in_byte_i == CH_QUOTE) begin
          dec.next_mode = MODE_NORMAL;
        end
      end
      MODE_ESC: begin
        dec.num       = 2'd1;
        dec.next_mode = MODE_STR;
      end
      default: begin
        // plain text; a slash on the last byte is not held
        if (in_byte_i == CH_SLASH && !eos_i) begin
          dec.next_mode = MODE_SLASH;
        end else begin
          dec.num       = 2'd1;
          dec.next_mode = (in_byte_i == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
    endcase
    // stream end starts the next stream in plain text
    if (eos_i) begin
      dec.next_mode = MODE_NORMAL;
    end
  end

  assign dec_o = dec;

endmodule

FILE: src/jcs_out_queue.sv
// ----------------------------------------------------------------------------
// jcs_out_queue
// two-entry result queue, takes up to two results and gives one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module jcs_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_num_i,
  input  jcs_pkg::jcs_res_t push0_i,
  input  jcs_pkg::jcs_res_t push1_i,
  input  logic              pop_ready_i,
  output logic              head_valid_o,
  output jcs_pkg::jcs_res_t head_o,
  output logic [1:0]        room_o
);
  import jcs_pkg::*;

  localparam logic [1:0] Depth = 2'd2;

  jcs_res_t   slot0_q, slot0_d;
  jcs_res_t   slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] kept;

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot0_q;
  assign pop          = head_valid_o && pop_ready_i;
  assign kept         = cnt_q - {1'b0, pop};
  assign room_o       = Depth - kept;

  always_comb begin
    slot0_d = pop ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    case (kept)
      2'd0: begin
        slot0_d = push0_i;
        slot1_d = push1_i;
      end
      2'd1: begin
        slot1_d = push0_i;
      end
      default: begin
        slot1_d = slot1_q;
      end
    endcase
    cnt_d = kept + push_num_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

FILE: src/json_comment_stripper_unit.sv
// ----------------------------------------------------------------------------
// json_comment_stripper_unit
// strips line and block comments from a byte stream, strings kept intact
// ----------------------------------------------------------------------------
//  channel  dir  payload                   handshake
//  in_i     in   in_byte, end_of_stream    valid / ready
//  out_o    out  out_byte, run_last        valid / ready
//
// one input item per cycle while the result queue has room; each taken item
// goes through the input register and then the result queue before its first
// result is offered; the two-entry result queue sets the rate: an item with two
// results waits in the input register until the queue has room for both
// reset puts the scanner in plain text with input register and queue empty
// input stalls only while the result queue has no room for the next item
// ----------------------------------------------------------------------------
module json_comment_stripper_unit (
  input logic       clk_i,
  input logic       rst_ni,
  jcs_in_if.sink    in_i,
  jcs_out_if.source out_o
);
  import jcs_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       eos_q;
  jcs_mode_e  mode_q, mode_d;
  jcs_dec_t   dec;
  logic [1:0] room;
  logic       fire;
  logic       accept;
  logic [1:0] push_num;
  logic       head_valid;
  jcs_res_t   head;

  jcs_decode u_decode (
    .mode_i    (mode_q),
    .in_byte_i (byte_q),
    .eos_i     (eos_q),
    .dec_o     (dec)
  );

  assign fire     = in_vld_q && (dec.num <= room);
  assign push_num = fire ? dec.num : 2'd0;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !in_vld_q || fire;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    mode_d = fire ? dec.next_mode : mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_NORMAL;
    end else begin
      in_vld_q <= in_vld_d;
      mode_q   <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.in_byte;
      eos_q  <= in_i.end_of_stream;
    end
  end

  jcs_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_num_i   (push_num),
    .push0_i      (dec.res0),
    .push1_i      (dec.res1),
    .pop_ready_i  (out_o.ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .room_o       (room)
  );

  assign out_o.valid    = head_valid;
  assign out_o.out_byte = head.out_byte;
  assign out_o.run_last = head.run_last;

endmodule

FILE: src/jcs_checker.sv
// ----------------------------------------------------------------------------
// jcs_checker
// port-level checks of the comment stripper, bound to the top level
// ----------------------------------------------------------------------------
`include "json_comment_stripper_unit_macros.svh"

module jcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_run_last_i
);
  import jcs_pkg::*;

  `JCS_ASSERT(a_out_valid_held, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "output item dropped while stalled")
  `JCS_ASSERT_HOLD(a_out_payload_held, clk_i, rst_ni, out_valid_i, out_ready_i, {out_byte_i, out_run_last_i}, "output item changed while stalled")
  // only a released slash is ever followed by a second result
  `JCS_ASSERT(a_first_is_slash, clk_i, rst_ni, (out_valid_i && !out_run_last_i) |-> (out_byte_i == CH_SLASH), "non-final result is not a slash")
  `JCS_ASSERT(a_pair_follows, clk_i, rst_ni, (out_valid_i && out_ready_i && !out_run_last_i) |=> out_valid_i, "second result of a pair missing")
  // input backpressure comes only from results waiting
  `JCS_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_i |-> out_valid_i, "input stalled with no result waiting")

endmodule

bind json_comment_stripper_unit jcs_checker u_jcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_run_last_i (out_o.run_last)
);

FILE: tb/json_comment_stripper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_comment_stripper_unit_test
// streams text bytes into the comment stripper and checks every kept byte
// against a scan-mode predictor, under sender idling, receiver stalls and a
// long receiver hold-off
// ----------------------------------------------------------------------------
module json_comment_stripper_unit_test;
  import jcs_pkg::*;

  typedef struct {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_item_t;

  logic clk;
  logic rst_n;

  jcs_in_if  in_bus ();
  jcs_out_if out_bus ();

  json_comment_stripper_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  text_item_t text_q[$];
  jcs_res_t   kept_q[$];
  jcs_mode_e  scan_st = MODE_NORMAL;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int stall_left = 0;
  int bytes_in   = 0;
  int bytes_out  = 0;
  int streams    = 0;
  int mismatches = 0;

  string plain_set = "abcdefxyz0123456789 :,{}[]-.tnu";

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // expected kept bytes for one accepted text byte
  task automatic strip_byte(input logic [7:0] b, input logic eos);
    logic [7:0] kept [2];
    int         n;
    jcs_res_t   r;
    jcs_mode_e  nxt;
    n   = 0;
    nxt = scan_st;
    case (scan_st)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          nxt = MODE_LINE;
        end else if (b == CH_STAR) begin
          nxt = MODE_BLOCK;
        end else begin
          kept[0] = CH_SLASH;
          kept[1] = b;
          n       = 2;
          nxt     = (b == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) begin
          kept[0] = b;
          n       = 1;
          nxt     = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) nxt = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        if (b == CH_SLASH) nxt = MODE_NORMAL;
        else if (b != CH_STAR) nxt = MODE_BLOCK;
      end
      MODE_STR: begin
        kept[0] = b;
        n       = 1;
        if (b == CH_BSLASH) nxt = MODE_ESC;
        else if (b == CH_QUOTE) nxt = MODE_NORMAL;
      end
      MODE_ESC: begin
        kept[0] = b;
        n       = 1;
        nxt     = MODE_STR;
      end
      default: begin
        // a slash on the final byte cannot open a comment, so it goes out at once
        if (b == CH_SLASH && !eos) begin
          nxt = MODE_SLASH;
        end else begin
          kept[0] = b;
          n       = 1;
          nxt     = (b == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      r.out_byte = kept[i];
      r.run_last = (i == n - 1);
      kept_q = {kept_q, r};
    end
    scan_st = eos ? MODE_NORMAL : nxt;
  endtask

  function automatic logic [7:0] plain_char();
    return plain_set[$urandom_range(plain_set.len() - 1)];
  endfunction

  function automatic void add(ref text_item_t s[$], input logic [7:0] b);
    text_item_t it;
    it.text_byte = b;
    it.last_byte = 1'b0;
    s = {s, it};
  endfunction

  // one stream of mostly well-formed text with comments and strings
  task automatic queue_stream(output int len);
    text_item_t s[$];
    logic [7:0] c;
    int         tokens;
    tokens = $urandom_range(3, 12);
    repeat (tokens) begin
      case ($urandom_range(11))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 6)) add(s, plain_char());
        end
        4, 5: begin
          add(s, CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(5))
              0: begin
                add(s, CH_BSLASH);
                add(s, 8'($urandom_range(255)));
              end
              1: add(s, $urandom_range(1) ? CH_STAR : CH_SLASH);
              default: add(s, plain_char());
            endcase
          end
          add(s, CH_QUOTE);
        end
        6: begin
          add(s, CH_SLASH);
          add(s, CH_SLASH);
          repeat ($urandom_range(0, 8)) begin
            c = 8'($urandom_range(255));
            add(s, (c == CH_NL) ? CH_STAR : c);
          end
          add(s, CH_NL);
        end
        7: begin
          add(s, CH_SLASH);
          add(s, CH_STAR);
          repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(4))
              0: add(s, CH_STAR);
              1: add(s, CH_SLASH);
              2: add(s, CH_NL);
              default: add(s, plain_char());
            endcase
          end
          repeat ($urandom_range(1, 3)) add(s, CH_STAR);
          add(s, CH_SLASH);
        end
        8: begin
          add(s, CH_SLASH);
          add(s, $urandom_range(3) == 0 ? CH_QUOTE : plain_char());
        end
        9: add(s, $urandom_range(1) ? CH_NL : 8'h20);
        10: begin
          repeat ($urandom_range(1, 3)) add(s, 8'($urandom_range(255)));
        end
        default: begin
          // broken fragments, kept rare so most streams stay well formed
          if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
              0: begin
                add(s, CH_SLASH);
                add(s, CH_STAR);
              end
              1: add(s, CH_QUOTE);
              2: begin
                add(s, CH_STAR);
                add(s, CH_SLASH);
              end
              default: begin
                add(s, CH_SLASH);
                add(s, CH_BSLASH);
              end
            endcase
          end
        end
      endcase
    end
    // odd endings: a slash, star or backslash as the final byte
    if ($urandom_range(5) == 0) begin
      case ($urandom_range(2))
        0: add(s, CH_SLASH);
        1: add(s, CH_STAR);
        default: add(s, CH_BSLASH);
      endcase
    end
    if (s.size() == 0) add(s, plain_char());
    s[s.size() - 1].last_byte = 1'b1;
    foreach (s[i]) text_q = {text_q, s[i]};
    len = s.size();
    streams++;
  endtask

  task automatic drain();
    while (text_q.size() != 0 || in_bus.valid || kept_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int target);
    int queued;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    queued    = 0;
    while (queued < target) begin
      queue_stream(len);
      queued += len;
    end
    drain();
  endtask

  // sender
  always @(posedge clk or negedge rst_n) begin : text_driver
    text_item_t it;
    if (!rst_n) begin
      in_bus.valid         <= 1'b0;
      in_bus.in_byte       <= '0;
      in_bus.end_of_stream <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = text_q.pop_front();
        in_bus.valid         <= 1'b1;
        in_bus.in_byte       <= it.text_byte;
        in_bus.end_of_stream <= it.last_byte;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      stall_left    <= 300;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : kept_checker
    jcs_res_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        strip_byte(in_bus.in_byte, in_bus.end_of_stream);
        bytes_in++;
      end
      if (out_bus.valid && out_bus.ready) begin
        bytes_out++;
        if (kept_q.size() == 0) begin
          $error("unexpected item: out_byte %h run_last %b", out_bus.out_byte,
                 out_bus.run_last);
          mismatches++;
        end else begin
          want = kept_q.pop_front();
          if (out_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_bus.out_byte);
            mismatches++;
          end
          if (out_bus.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_bus.run_last);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [8:0] directed [25];
    text_item_t it;
    // {final byte, text byte}
    directed = '{
      {1'b1, CH_SLASH},
      {1'b0, CH_SLASH}, {1'b0, CH_QUOTE}, {1'b0, 8'h78}, {1'b0, CH_BSLASH},
      {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b1, CH_NL},
      {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h00}, {1'b0, CH_NL},
      {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, 8'h78},
      {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_SLASH}, {1'b1, 8'hFF},
      {1'b0, CH_SLASH}, {1'b1, CH_STAR}, {1'b1, 8'h71},
      {1'b0, CH_QUOTE}, {1'b1, CH_BSLASH}
    };
    in_bus.valid         = 1'b0;
    in_bus.in_byte       = '0;
    in_bus.end_of_stream = 1'b0;
    out_bus.ready        = 1'b0;
    rst_n                = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      it.text_byte = directed[i][7:0];
      it.last_byte = directed[i][8];
      text_q = {text_q, it};
    end
    drain();

    // receiver holds off while the sender keeps offering items
    hold_req++;
    run_phase(0, 0, 370);
    run_phase(67, 0, 370);
    run_phase(0, 67, 370);
    run_phase(14, 14, 370);

    $display("checked %0d kept bytes from %0d text bytes in %0d streams", bytes_out,
             bytes_in, streams);
    $display("covered free flow, sender gaps, receiver stalls, both, and a long hold-off");
    if (mismatches == 0 && kept_q.size() == 0) begin
      $display("json_comment_stripper_unit_test passed");
    end else begin
      $display("json_comment_stripper_unit_test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("json_comment_stripper_unit_test failed");
    $finish;
  end

endmodule
